// File: hw/rtl/ttau_pkg.sv
`default_nettype none

package ttau_pkg;

  localparam int MAX_DIM_DEF    = 8192;
  localparam int MAX_LEVELS_DEF = 14;

  // configuration port
  localparam int REG_ADDR_W = 4;
  localparam int REG_DATA_W = 32;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_MIPS   = 2'd3;

  // texel formats
  localparam logic [1:0] FMT_RGBA32 = 2'd0;
  localparam logic [1:0] FMT_BC8    = 2'd1;
  localparam logic [1:0] FMT_BC16   = 2'd2;
  localparam logic [1:0] FMT_RSVD   = 2'd3;

  typedef struct packed {
    logic [1:0]  texel_format;
    logic [13:0] width_px;
    logic [13:0] height_px;
    logic [3:0]  mip_count;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [12:0] elem_x;
    logic [12:0] elem_y;
  } coord_t;

  typedef struct packed {
    logic [31:0] tiled_addr;
    logic [31:0] linear_addr;
    logic [4:0]  elem_bytes;
    logic        in_range;
  } addr_t;

  typedef struct packed {
    logic load;
    logic accum;
    logic mul;
    logic off;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/ttau_regs.sv
`default_nettype none

module ttau_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ttau_pkg::REG_ADDR_W-1:0]  paddr,
  input  wire logic [ttau_pkg::REG_DATA_W-1:0]  pwdata,
  output logic      [ttau_pkg::REG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output ttau_pkg::cfg_t                        cfg
);
  import ttau_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.texel_format <= FMT_RGBA32;
      cfg.width_px     <= 14'd1;
      cfg.height_px    <= 14'd1;
      cfg.mip_count    <= 4'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FORMAT: cfg.texel_format <= pwdata[1:0];
        REG_WIDTH:  cfg.width_px     <= pwdata[13:0];
        REG_HEIGHT: cfg.height_px    <= pwdata[13:0];
        REG_MIPS:   cfg.mip_count    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORMAT: prdata = REG_DATA_W'(cfg.texel_format);
      REG_WIDTH:  prdata = REG_DATA_W'(cfg.width_px);
      REG_HEIGHT: prdata = REG_DATA_W'(cfg.height_px);
      REG_MIPS:   prdata = REG_DATA_W'(cfg.mip_count);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ttau_ctrl.sv
`default_nettype none

module ttau_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 coord_valid,
  output logic                      coord_ready,
  input  wire ttau_pkg::dp_status_t status,
  output ttau_pkg::dp_cmd_t         cmd
);
  import ttau_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACCUM = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_OFF   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign coord_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (coord_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        if (status.acc_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OFF;
      end
      S_OFF: begin
        cmd.off    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // wait here until the output register can take the result
        if (status.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ttau_dp.sv
`default_nettype none

module ttau_dp #(
  parameter int MAX_DIM    = ttau_pkg::MAX_DIM_DEF,
  parameter int MAX_LEVELS = ttau_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ttau_pkg::cfg_t       cfg,
  input  wire ttau_pkg::coord_t     coord,
  input  wire ttau_pkg::dp_cmd_t    cmd,
  output ttau_pkg::dp_status_t      status,
  output logic                      addr_valid,
  input  wire logic                 addr_ready,
  output ttau_pkg::addr_t           addr
);
  import ttau_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int AW    = DIM_W + 1;
  localparam int PW    = 2 * DIM_W;
  localparam int LW    = 13 + DIM_W;
  localparam int MW    = 9 + AW;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [13:0] d);
    if (d == 14'd0) begin
      return DIM_W'(1);
    end else if (32'(d) > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(d);
  endfunction

  function automatic logic [DIM_W-1:0] level_dim(input logic [DIM_W-1:0] d,
                                                 input logic [3:0] sh,
                                                 input logic blk);
    logic [DIM_W-1:0] v;
    v = d >> sh;
    if (v == '0) v = DIM_W'(1);
    if (blk) begin
      v = v >> 2;
      if (v == '0) v = DIM_W'(1);
    end
    return v;
  endfunction

  // captured item and running state
  logic [3:0]       lvl_q;
  logic [12:0]      x_q;
  logic [12:0]      y_q;
  logic [3:0]       cnt;
  logic [31:0]      base;
  logic [DIM_W-1:0] ew_q;
  logic [DIM_W-1:0] eh_q;
  logic [31:0]      size_q;
  logic [LW-1:0]    lin_q;
  logic [MW-1:0]    mac_q;
  logic [31:0]      toff;
  logic [31:0]      loff;

  logic             blk;
  logic [2:0]       lb;
  logic [2:0]       mshift;
  logic [2:0]       lu;
  logic [3:0]       mips;
  logic [3:0]       lim;
  logic [3:0]       idx;
  logic [DIM_W-1:0] ew_c;
  logic [DIM_W-1:0] eh_c;
  logic [PW-1:0]    prod_c;
  logic [31:0]      size_c;
  logic [AW-1:0]    aligned;
  logic [AW-1:0]    mpr;
  logic [LW-1:0]    lin_c;
  logic [MW-1:0]    mac_c;

  logic [31:0]      macro_idx;
  logic [31:0]      macro_off;
  logic [12:0]      lx;
  logic [3:0]       ly;
  logic [31:0]      micro_idx;
  logic [3:0]       micro_sh;
  logic [31:0]      micro_off;
  logic [31:0]      inner;
  logic [31:0]      toff_c;
  logic [31:0]      loff_c;
  logic [4:0]       ebytes;
  logic             ok_c;

  assign blk = (cfg.texel_format == FMT_BC8) || (cfg.texel_format == FMT_BC16);

  always_comb begin
    unique case (cfg.texel_format)
      FMT_BC8:  lb = 3'd3;
      FMT_BC16: lb = 3'd4;
      default:  lb = 3'd2;
    endcase
  end

  // macro tile pitch is 128 bytes, micro tiles are 4 wide for blocks, 8 for color
  assign mshift = 3'd7 - lb;
  assign lu     = (lb >= 3'd3) ? 3'd2 : 3'd3;
  assign ebytes = 5'd1 << lb;

  assign mips = (cfg.mip_count > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : cfg.mip_count;
  assign lim  = (lvl_q < mips) ? lvl_q : mips;
  assign status.acc_done = (cnt >= lim);
  assign status.out_free = !addr_valid || addr_ready;

  // one level's grid: earlier levels while summing, then the addressed one
  assign idx    = cmd.accum ? cnt : lvl_q;
  assign ew_c   = level_dim(clamp_dim(cfg.width_px), idx, blk);
  assign eh_c   = level_dim(clamp_dim(cfg.height_px), idx, blk);
  assign prod_c = PW'(ew_c) * PW'(eh_c);
  assign size_c = 32'(prod_c) << lb;

  assign aligned = (AW'(ew_c) + AW'(31)) & ~AW'(31);
  assign mpr     = aligned >> mshift;
  assign lin_c   = LW'(y_q) * LW'(ew_c);
  assign mac_c   = MW'(y_q[12:4]) * MW'(mpr);

  // tiled offset from the registered products
  assign macro_idx = 32'(mac_q) + 32'(x_q >> mshift);
  assign macro_off = macro_idx << 11;
  assign lx        = x_q & ((13'd1 << mshift) - 13'd1);
  assign ly        = y_q[3:0];
  assign micro_idx = (32'(ly[3:2]) << (mshift - lu)) + 32'(lx >> lu);
  assign micro_sh  = 4'(lu) + 4'd2 + 4'(lb);
  assign micro_off = micro_idx << micro_sh;
  assign inner     = ((32'(ly[1:0]) << lu) + 32'(lx & ((13'd1 << lu) - 13'd1))) << lb;
  assign toff_c    = macro_off + micro_off + inner;
  assign loff_c    = (32'(lin_q) + 32'(x_q)) << lb;

  assign ok_c = (cfg.texel_format != FMT_RSVD) && (lvl_q < mips)
             && (32'(x_q) < 32'(ew_q)) && (32'(y_q) < 32'(eh_q))
             && ((33'(toff) + 33'(ebytes)) <= 33'(size_q));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl_q <= coord.level;
      x_q   <= coord.elem_x;
      y_q   <= coord.elem_y;
      cnt   <= 4'd0;
      base  <= 32'd0;
    end else if (cmd.accum && !status.acc_done) begin
      base <= base + size_c;
      cnt  <= cnt + 4'd1;
    end
    if (cmd.mul) begin
      ew_q   <= ew_c;
      eh_q   <= eh_c;
      size_q <= size_c;
      lin_q  <= lin_c;
      mac_q  <= mac_c;
    end
    if (cmd.off) begin
      toff <= toff_c;
      loff <= loff_c;
    end
    if (cmd.fin) begin
      addr.tiled_addr  <= base + toff;
      addr.linear_addr <= base + loff;
      addr.elem_bytes  <= ebytes;
      addr.in_range    <= ok_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else if (cmd.fin) begin
      addr_valid <= 1'b1;
    end else if (addr_ready) begin
      addr_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tiled_texture_address_unit.sv
// Tiled texture address unit.
// Software sets texel format, base width and height and mip count through the
// APB-style port while the unit is idle; writes land when psel, penable and
// pwrite are high (pready is tied high), reads return the register value.
// A coordinate transaction (level, elem_x, elem_y) on the coord channel yields
// one address transaction (tiled and linear byte address, bytes per element,
// in-range flag) on the addr channel.
// The coordinate is captured (load), the level base is summed from the sizes of
// the min(level, mip count) levels below it, one level size per cycle (accum),
// then the level's products (mul) and offsets (off) are registered, and fin
// writes the output register; only then is the next coordinate taken.
// The output register frees the unit: a new coordinate may be taken while
// the previous result still waits for addr_ready. If the receiver stalls, the
// finished result waits inside the unit until the output register drains.
// Reset (rst, synchronous) returns the registers to format 0, 1x1, one mip
// level, empties the output register and leaves the unit ready for input.
`default_nettype none

module tiled_texture_address_unit #(
  parameter int MAX_DIM    = ttau_pkg::MAX_DIM_DEF,
  parameter int MAX_LEVELS = ttau_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ttau_pkg::REG_ADDR_W-1:0]  paddr,
  input  wire logic [ttau_pkg::REG_DATA_W-1:0]  pwdata,
  output logic      [ttau_pkg::REG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  input  wire logic                             coord_valid,
  output logic                                  coord_ready,
  input  wire ttau_pkg::coord_t                 coord,
  output logic                                  addr_valid,
  input  wire logic                             addr_ready,
  output ttau_pkg::addr_t                       addr
);
  import ttau_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  ttau_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ttau_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .coord_valid (coord_valid),
    .coord_ready (coord_ready),
    .status      (status),
    .cmd         (cmd)
  );

  ttau_dp #(
    .MAX_DIM    (MAX_DIM),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .coord      (coord),
    .cmd        (cmd),
    .status     (status),
    .addr_valid (addr_valid),
    .addr_ready (addr_ready),
    .addr       (addr)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.accum, cmd.mul, cmd.off, cmd.fin}))
    else $error("more than one datapath command at once");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (coord_valid && coord_ready) |=> !coord_ready)
    else $error("coordinate taken while an item is in flight");

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> status.out_free)
    else $error("result written over an untaken result");

  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> addr_valid)
    else $error("finished result not presented");

endmodule

`default_nettype wire
